### src/bdasc_pkg.sv
// Shared constants and types for the binary to decimal ASCII converter.
// No dependencies.
package bdasc_pkg;

  localparam int DigitSlots = 8;
  localparam int DigitW     = 4;
  localparam int CharW      = 6;
  localparam int BcdW       = DigitSlots * DigitW;
  localparam int SatBits    = 27;
  localparam int IdxW       = 3;

  localparam logic [SatBits-1:0] SatLimit  = 27'd99999999;
  localparam logic [CharW-1:0]   AsciiZero = 6'h30;
  localparam logic [DigitW-1:0]  DigitFive = 4'd5;
  localparam logic [DigitW-1:0]  DigitAdj  = 4'd3;

  typedef struct packed {
    logic [CharW-1:0] digit_char;
    logic             last;
  } char_t;

endpackage

### src/bdasc_if.sv
// Handshake channels: binary value in, ASCII digit word out.
// Depends on bdasc_pkg.
interface bdasc_value_if #(
  parameter int VALUE_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bdasc_char_if
  import bdasc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] digit_char;
  logic             last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

### src/bdasc_front.sv
// Input stage: accepts a value, saturates it to eight decimal digits, registers it.
// Depends on bdasc_pkg and bdasc_value_if.
module bdasc_front
  import bdasc_pkg::*;
#(
  parameter int VALUE_BITS = 24,
  parameter int CvtBits    = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bdasc_value_if.sink        value_i,
  output logic               push_o,
  output logic [CvtBits-1:0] push_data_o,
  input  logic               push_ready_i
);

  localparam int ExtBits = (VALUE_BITS > SatBits) ? VALUE_BITS : SatBits;

  logic               vld_q;
  logic [CvtBits-1:0] data_q;
  logic [ExtBits-1:0] ext;
  logic [ExtBits-1:0] sat;
  logic               take;

  assign ext = ExtBits'(value_i.value);
  assign sat = (ext > ExtBits'(SatLimit)) ? ExtBits'(SatLimit) : ext;

  assign value_i.ready = !vld_q || push_ready_i;
  assign take          = value_i.valid && value_i.ready;
  assign push_o        = vld_q;
  assign push_data_o   = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (push_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= sat[CvtBits-1:0];
    end
  end

endmodule

### src/bdasc_fifo.sv
// Two-entry queue between the input stage and the converter.
// Depends on bdasc_pkg.
module bdasc_fifo
  import bdasc_pkg::*;
#(
  parameter int Width = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output logic [Width-1:0] pop_data_o,
  input  logic             pop_i
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### src/bdasc_back.sv
// Converter: shift-add-3 to BCD, one bit per cycle, then emits digits MSB first.
// Depends on bdasc_pkg and bdasc_char_if.
module bdasc_back
  import bdasc_pkg::*;
#(
  parameter int CvtBits = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  input  logic [CvtBits-1:0] pop_data_i,
  output logic               pop_o,
  bdasc_char_if.source       char_o
);

  localparam int CntW = $clog2(CvtBits + 1);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    cnt_q;
  logic [CvtBits-1:0] bin_q;
  logic [BcdW-1:0]    bcd_q;
  logic [BcdW-1:0]    adj;
  logic [IdxW-1:0]    top_idx;
  logic [IdxW-1:0]    idx_q;
  logic               ovld_q;
  char_t              out_q;
  logic               slot_free;
  logic               emit;
  logic [DigitW-1:0]  cur_digit;

  always_comb begin
    for (int i = 0; i < DigitSlots; i++) begin
      adj[i*DigitW +: DigitW] = (bcd_q[i*DigitW +: DigitW] >= DigitFive)
                              ? bcd_q[i*DigitW +: DigitW] + DigitAdj
                              : bcd_q[i*DigitW +: DigitW];
    end
  end

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < DigitSlots; i++) begin
      if (bcd_q[i*DigitW +: DigitW] != '0) begin
        top_idx = IdxW'(i);
      end
    end
  end

  assign cur_digit = bcd_q[idx_q*DigitW +: DigitW];
  assign slot_free = !ovld_q || char_o.ready;
  assign emit      = (state_q == StEmit) && (cnt_q != CntW'(CvtBits)) && slot_free;
  assign pop_o     = (state_q == StIdle) && pop_valid_i;

  assign char_o.valid      = ovld_q;
  assign char_o.digit_char = out_q.digit_char;
  assign char_o.last       = out_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovld_q  <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (emit) begin
        ovld_q <= 1'b1;
      end else if (char_o.ready) begin
        ovld_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (pop_valid_i) begin
            cnt_q   <= '0;
            state_q <= StConv;
          end
        end
        StConv: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(CvtBits - 1)) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (cnt_q == CntW'(CvtBits)) begin
            idx_q <= top_idx;
            cnt_q <= '0;
          end else if (slot_free) begin
            if (idx_q == '0) begin
              state_q <= StIdle;
            end else begin
              idx_q <= idx_q - IdxW'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bin_q <= pop_data_i;
      bcd_q <= '0;
    end else if (state_q == StConv) begin
      bcd_q <= {adj[BcdW-2:0], bin_q[CvtBits-1]};
      bin_q <= bin_q << 1;
    end
    if (emit) begin
      out_q.digit_char <= AsciiZero | CharW'(cur_digit);
      out_q.last       <= (idx_q == '0);
    end
  end

endmodule

### src/binary_to_decimal_ascii_top.sv
// Top level of the binary to decimal ASCII converter.
// Depends on bdasc_pkg, bdasc_if, bdasc_front, bdasc_fifo and bdasc_back.
//
// Takes an unsigned VALUE_BITS-wide value and returns its decimal text as ASCII
// digit words, most significant first, leading zeros dropped ('0' for zero),
// with last set on the final digit. Values above 99999999 saturate to it. The
// converter handles one value at a time: it takes the value from the queue, runs
// shift-add-3 over min(VALUE_BITS, 27) bits, locates the leading digit, then
// emits the digits in turn while the sink is ready. An input register and a
// two-entry queue let up to three further values be taken while a conversion
// is in progress.
module binary_to_decimal_ascii_top
  import bdasc_pkg::*;
#(
  parameter int VALUE_BITS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bdasc_value_if.sink  value_i,
  bdasc_char_if.source char_o
);

  localparam int CvtBits = (VALUE_BITS < SatBits) ? VALUE_BITS : SatBits;

  logic               push;
  logic [CvtBits-1:0] push_data;
  logic               push_ready;
  logic               pop_valid;
  logic [CvtBits-1:0] pop_data;
  logic               pop;

  bdasc_front #(
    .VALUE_BITS(VALUE_BITS),
    .CvtBits   (CvtBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .push_o      (push),
    .push_data_o (push_data),
    .push_ready_i(push_ready)
  );

  bdasc_fifo #(
    .Width(CvtBits)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .pop_i       (pop)
  );

  bdasc_back #(
    .CvtBits(CvtBits)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .char_o     (char_o)
  );

endmodule

### src/bdasc_checker.sv
// Port-level checks for the converter top level, with its bind.
// Depends on bdasc_pkg.
module bdasc_checker
  import bdasc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CharW-1:0] digit_char_i,
  input logic             last_i
);

  logic       first_q;
  logic [3:0] pend_q;
  logic       in_fire;
  logic       run_end;

  assign in_fire = in_valid_i && in_ready_i;
  assign run_end = out_valid_i && out_ready_i && last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      pend_q  <= '0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        first_q <= last_i;
      end
      if (in_fire && !run_end) begin
        pend_q <= pend_q + 4'd1;
      end else if (run_end && !in_fire) begin
        pend_q <= pend_q - 4'd1;
      end
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(digit_char_i) && $stable(last_i))
    else $error("output word changed while stalled");

  a_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> digit_char_i[5:4] == 2'b11 && digit_char_i[3:0] <= 4'd9)
    else $error("output is not a decimal digit");

  a_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && first_q && !last_i |-> digit_char_i != AsciiZero)
    else $error("leading zero emitted");

  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 4'd0)
    else $error("output with no value outstanding");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'd5)
    else $error("more values held than storage allows");

endmodule

bind binary_to_decimal_ascii_top bdasc_checker u_bdasc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (value_i.valid),
  .in_ready_i  (value_i.ready),
  .out_valid_i (char_o.valid),
  .out_ready_i (char_o.ready),
  .digit_char_i(char_o.digit_char),
  .last_i      (char_o.last)
);
